### sv/ssa_pkg.sv
package ssa_pkg;

  // default geometry
  localparam int LINE_COUNT_DEF = 240;
  localparam int VIEW_WIDTH_DEF = 320;

  // field widths
  localparam int OP_W       = 2;
  localparam int COORD_W    = 11;
  localparam int LINE_IN_W  = 8;
  localparam int HORIZON_W  = 10;
  localparam int WIN_W      = 10;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  // internal widths: column/row arithmetic and stored span ends
  localparam int CALC_W     = 13;
  localparam int SPAN_W     = 11;
  localparam int LIMIT_W    = 10;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR_ALL = 2'd0,
    OP_CLEAR_BOX = 2'd1,
    OP_ADD_QUAD  = 2'd2,
    OP_READ_LINE = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_CENTER   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_ORIGIN = 1'd1;

  localparam logic [CFG_W-1:0] LINE_CENTER_RESET   = 8'd120;
  localparam logic [CFG_W-1:0] COLUMN_ORIGIN_RESET = 8'd0;

  // shut window and empty span encodings
  localparam logic [WIN_W-1:0]  SHUT_START  = 10'h3ff;
  localparam logic [WIN_W-1:0]  SHUT_END    = 10'h000;
  localparam logic [SPAN_W-1:0] LEFT_EMPTY  = 11'h7ff;
  localparam logic [SPAN_W-1:0] RIGHT_EMPTY = 11'h7ff;

  // controller to datapath commands
  typedef struct packed {
    logic box_clear;
    logic quad_load;
    logic clr_start;
    logic clr_write;
    logic q_read;
    logic q_write;
    logic rd_read;
    logic out_load;
  } ssa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic quad_go;
    logic line_end;
    logic line_last;
  } ssa_sts_t;

endpackage

### sv/scanline_span_accumulator_unit.sv
// Scanline span accumulator: a left/right span per raster line plus a bounding box.
// Input channel (in_valid/in_ready) carries one request: clear all, clear box,
// add quad or read line. Only a read returns a result, on the out_valid/out_ready
// channel: the line's window, the box and an empty-box flag.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) must be written only while idle;
// the block does not enforce it; index 0 is line_center, index 1 is column_origin.
// Work per request; the span memory is walked one line a cycle:
//   clear box: the box resets on acceptance and no walk follows
//   read line: the span read is loaded into the result register, raising out_valid
//   add quad:  the box grows; a quad that still covers lines after clipping is then
//              walked line by line; clear all: the box resets and a sweep clears every line
// After reset the span memory is cleared by the same sweep: in_ready stays low
// until the sweep ends. Configuration registers and the box reset at once.
// The result sits in an output register, so other requests are taken while it
// waits; a second read holds in its final cycle until the register is free,
// and in_ready stays low meanwhile.
module scanline_span_accumulator_unit import ssa_pkg::*; #(
  parameter int LINE_COUNT = LINE_COUNT_DEF,
  parameter int VIEW_WIDTH = VIEW_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             in_operation,
  input  logic signed [COORD_W-1:0]   in_left_x,
  input  logic signed [COORD_W-1:0]   in_top_y,
  input  logic signed [COORD_W-1:0]   in_right_x,
  input  logic signed [COORD_W-1:0]   in_bottom_y,
  input  logic [LINE_IN_W-1:0]        in_line_index,
  input  logic signed [HORIZON_W-1:0] in_horizon_line,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [WIN_W-1:0]            out_window_start,
  output logic [WIN_W-1:0]            out_window_end,
  output logic                        out_box_empty,
  output logic signed [COORD_W-1:0]   out_box_x_min,
  output logic signed [COORD_W-1:0]   out_box_y_min,
  output logic signed [COORD_W-1:0]   out_box_x_max,
  output logic signed [COORD_W-1:0]   out_box_y_max,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata
);

  ssa_cmd_t cmd;
  ssa_sts_t sts;

  // sequencer
  ssa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  // spans, box and result register
  ssa_dp #(
    .LINE_COUNT (LINE_COUNT),
    .VIEW_WIDTH (VIEW_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_left_x        (in_left_x),
    .in_top_y         (in_top_y),
    .in_right_x       (in_right_x),
    .in_bottom_y      (in_bottom_y),
    .in_line_index    (in_line_index),
    .in_horizon_line  (in_horizon_line),
    .out_window_start (out_window_start),
    .out_window_end   (out_window_end),
    .out_box_empty    (out_box_empty),
    .out_box_x_min    (out_box_x_min),
    .out_box_y_min    (out_box_y_min),
    .out_box_x_max    (out_box_x_max),
    .out_box_y_max    (out_box_y_max),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

### sv/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ssa_ctrl.sv
module ssa_ctrl import ssa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  ssa_sts_t        sts,
  output ssa_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUAD,
    S_DRAIN,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   wb_r, wb_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.line_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_CLEAR_ALL: begin
              cmd.box_clear = 1'b1;
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLEAR;
            end
            OP_CLEAR_BOX: begin
              cmd.box_clear = 1'b1;
            end
            OP_ADD_QUAD: begin
              cmd.quad_load = 1'b1;
              if (sts.quad_go) begin
                state_nxt = S_QUAD;
              end
            end
            OP_READ_LINE: begin
              cmd.rd_read = 1'b1;
              state_nxt   = S_READ;
            end
          endcase
        end
      end
      S_QUAD: begin
        cmd.q_read = 1'b1;
        if (sts.line_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.q_write = wb_r;
  end

  // write-back comes in the cycle after each span read
  assign wb_nxt = cmd.q_read;

  // result register valid
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_r        <= wb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // no request is taken while a span write-back is pending
  a_wb_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wb_r |-> !in_ready)
    else $error("request taken during span write-back");

  // the result register is never overwritten while it still holds a result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_ready)
    else $error("result overwritten before it was taken");

  // the last span read is always followed by its write-back
  a_last_line_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUAD && sts.line_end) |=> (state_r == S_DRAIN && wb_r))
    else $error("last span line not written back");

  // the clear sweep runs until the last line
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && !sts.line_last) |=> (state_r == S_CLEAR))
    else $error("clear sweep ended early");
`endif

endmodule

### sv/ssa_dp.sv
module ssa_dp import ssa_pkg::*; #(
  parameter int LINE_COUNT = LINE_COUNT_DEF,
  parameter int VIEW_WIDTH = VIEW_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata,
  input  logic signed [COORD_W-1:0]   in_left_x,
  input  logic signed [COORD_W-1:0]   in_top_y,
  input  logic signed [COORD_W-1:0]   in_right_x,
  input  logic signed [COORD_W-1:0]   in_bottom_y,
  input  logic [LINE_IN_W-1:0]        in_line_index,
  input  logic signed [HORIZON_W-1:0] in_horizon_line,
  output logic [WIN_W-1:0]            out_window_start,
  output logic [WIN_W-1:0]            out_window_end,
  output logic                        out_box_empty,
  output logic signed [COORD_W-1:0]   out_box_x_min,
  output logic signed [COORD_W-1:0]   out_box_y_min,
  output logic signed [COORD_W-1:0]   out_box_x_max,
  output logic signed [COORD_W-1:0]   out_box_y_max,
  input  ssa_cmd_t                    cmd,
  output ssa_sts_t                    sts
);

  localparam int LW = $clog2(LINE_COUNT);
  localparam logic [LW-1:0]      LINE_LAST  = LW'(LINE_COUNT - 1);
  localparam logic [LIMIT_W-1:0] LINE_LIMIT = LIMIT_W'(LINE_COUNT);
  localparam logic signed [CALC_W-1:0] LAST_ROW  = CALC_W'(LINE_COUNT - 1);
  localparam logic signed [CALC_W-1:0] HALF_VIEW = CALC_W'(VIEW_WIDTH / 2);
  localparam logic signed [CALC_W-1:0] VIEW_LAST = CALC_W'(VIEW_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] BOX_X_MIN_RST = COORD_W'(VIEW_WIDTH / 2);
  localparam logic signed [COORD_W-1:0] BOX_Y_MIN_RST = COORD_W'(LINE_COUNT / 2);
  localparam logic signed [COORD_W-1:0] BOX_X_MAX_RST = COORD_W'(-(VIEW_WIDTH / 2));
  localparam logic signed [COORD_W-1:0] BOX_Y_MAX_RST = COORD_W'(-(LINE_COUNT / 2));

  logic [CFG_W-1:0]            line_center_r, column_origin_r;
  logic signed [COORD_W-1:0]   box_x_min_r, box_y_min_r, box_x_max_r, box_y_max_r;
  logic [LW-1:0]               line_r, line_nxt, wline_r, y_end_r;
  logic [SPAN_W-1:0]           x0_r, x1_r;
  logic                        shut_r;
  logic signed [CALC_W-1:0]    lc_ext, org_ext;
  logic signed [CALC_W-1:0]    y0_s, y1_s, y0_c, y1_c, x0_s, x1_s, x0_c, x1_c;
  logic signed [COORD_W-1:0]   line_ext, horizon_ext;
  logic                        line_in_range;
  logic                        ram_we, ram_re;
  logic [LW-1:0]               ram_waddr, ram_raddr;
  logic [2*SPAN_W-1:0]         ram_wdata, ram_rdata;
  logic [SPAN_W-1:0]           left_q, right_q, left_new, right_new;
  logic                        open;
  logic [WIN_W-1:0]            win_start_r, win_end_r;
  logic                        box_empty_r;
  logic signed [COORD_W-1:0]   o_x_min_r, o_y_min_r, o_x_max_r, o_y_max_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_center_r   <= LINE_CENTER_RESET;
      column_origin_r <= COLUMN_ORIGIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LINE_CENTER:   line_center_r   <= cfg_wdata;
        REG_COLUMN_ORIGIN: column_origin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shift and clip the quad to the screen
  assign lc_ext  = $signed({{(CALC_W-CFG_W){1'b0}}, line_center_r});
  assign org_ext = $signed({{(CALC_W-CFG_W){1'b0}}, column_origin_r});
  assign y0_s    = CALC_W'(in_top_y) + lc_ext;
  assign y1_s    = CALC_W'(in_bottom_y) + lc_ext;
  assign x0_s    = CALC_W'(in_left_x) + HALF_VIEW + org_ext;
  assign x1_s    = CALC_W'(in_right_x) + HALF_VIEW + org_ext;
  assign y0_c    = y0_s[CALC_W-1] ? '0 : y0_s;
  assign y1_c    = (y1_s > LAST_ROW) ? LAST_ROW : y1_s;
  assign x0_c    = (x0_s < org_ext) ? org_ext : x0_s;
  assign x1_c    = (x1_s > VIEW_LAST + org_ext) ? (VIEW_LAST + org_ext) : x1_s;

  assign sts.quad_go   = (y0_c <= y1_c) && (x1_c >= x0_c);
  assign sts.line_end  = (line_r == y_end_r);
  assign sts.line_last = (line_r == LINE_LAST);

  // bounding box
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.box_clear) begin
      box_x_min_r <= BOX_X_MIN_RST;
      box_y_min_r <= BOX_Y_MIN_RST;
      box_x_max_r <= BOX_X_MAX_RST;
      box_y_max_r <= BOX_Y_MAX_RST;
    end else if (cmd.quad_load) begin
      if (in_left_x < box_x_min_r) box_x_min_r <= in_left_x;
      if (in_top_y < box_y_min_r) box_y_min_r <= in_top_y;
      if (in_right_x > box_x_max_r) box_x_max_r <= in_right_x;
      if (in_bottom_y > box_y_max_r) box_y_max_r <= in_bottom_y;
    end
  end

  // line counter for the clear sweep and the quad walk
  always_comb begin
    priority if (cmd.clr_start) begin
      line_nxt = '0;
    end else if (cmd.quad_load) begin
      line_nxt = y0_c[LW-1:0];
    end else if (cmd.q_read || cmd.clr_write) begin
      line_nxt = line_r + 1'b1;
    end else begin
      line_nxt = line_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else begin
      line_r <= line_nxt;
    end
  end

  // quad and read request operands
  assign line_ext      = $signed({{(COORD_W-LINE_IN_W){1'b0}}, in_line_index});
  assign horizon_ext   = COORD_W'(in_horizon_line);
  assign line_in_range = ({{(LIMIT_W-LINE_IN_W){1'b0}}, in_line_index} < LINE_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.quad_load) begin
      y_end_r <= y1_c[LW-1:0];
      x0_r    <= x0_c[SPAN_W-1:0];
      x1_r    <= x1_c[SPAN_W-1:0];
    end
    if (cmd.rd_read) begin
      shut_r <= !line_in_range || (line_ext < horizon_ext);
    end
    if (cmd.q_read) begin
      wline_r <= line_r;
    end
  end

  // span read-modify-write
  assign left_q    = ram_rdata[2*SPAN_W-1:SPAN_W];
  assign right_q   = ram_rdata[SPAN_W-1:0];
  assign left_new  = (x0_r < left_q) ? x0_r : left_q;
  assign right_new = ($signed(x1_r) > $signed(right_q)) ? x1_r : right_q;

  assign ram_we    = cmd.clr_write || cmd.q_write;
  assign ram_waddr = cmd.clr_write ? line_r : wline_r;
  assign ram_wdata = cmd.clr_write ? {LEFT_EMPTY, RIGHT_EMPTY} : {left_new, right_new};
  assign ram_re    = cmd.q_read || cmd.rd_read;
  assign ram_raddr = cmd.rd_read ? LW'(in_line_index) : line_r;

  ssa_ram #(
    .WIDTH (2 * SPAN_W),
    .DEPTH (LINE_COUNT)
  ) u_span_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // result register
  assign open = !shut_r &&
                !($signed({1'b0, left_q}) > $signed({right_q[SPAN_W-1], right_q}));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      win_start_r <= open ? left_q[WIN_W-1:0] : SHUT_START;
      win_end_r   <= open ? right_q[WIN_W-1:0] : SHUT_END;
      box_empty_r <= (box_x_min_r > box_x_max_r) || (box_y_min_r > box_y_max_r);
      o_x_min_r   <= box_x_min_r;
      o_y_min_r   <= box_y_min_r;
      o_x_max_r   <= box_x_max_r;
      o_y_max_r   <= box_y_max_r;
    end
  end

  assign out_window_start = win_start_r;
  assign out_window_end   = win_end_r;
  assign out_box_empty    = box_empty_r;
  assign out_box_x_min    = o_x_min_r;
  assign out_box_y_min    = o_y_min_r;
  assign out_box_x_max    = o_x_max_r;
  assign out_box_y_max    = o_y_max_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ssa_pkg::*;

  localparam int LINES = LINE_COUNT_DEF;
  localparam int VIEW = VIEW_WIDTH_DEF;
  localparam int SPAN_NONE = 'h3fff;
  localparam int SETTLE_CYCLES = LINES + 20;
  localparam int QUIET_LIMIT = 5000;

  // one request as presented on the input channel
  typedef struct {
    op_t                         op;
    logic signed [COORD_W-1:0]   lx;
    logic signed [COORD_W-1:0]   ty;
    logic signed [COORD_W-1:0]   rx;
    logic signed [COORD_W-1:0]   by;
    logic [LINE_IN_W-1:0]        line;
    logic signed [HORIZON_W-1:0] hz;
  } span_req_t;

  // one line window report as returned by a read
  typedef struct {
    logic [WIN_W-1:0]          wstart;
    logic [WIN_W-1:0]          wend;
    logic                      empty;
    logic signed [COORD_W-1:0] xmin;
    logic signed [COORD_W-1:0] ymin;
    logic signed [COORD_W-1:0] xmax;
    logic signed [COORD_W-1:0] ymax;
  } window_rpt_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [OP_W-1:0]             in_operation;
  logic signed [COORD_W-1:0]   in_left_x;
  logic signed [COORD_W-1:0]   in_top_y;
  logic signed [COORD_W-1:0]   in_right_x;
  logic signed [COORD_W-1:0]   in_bottom_y;
  logic [LINE_IN_W-1:0]        in_line_index;
  logic signed [HORIZON_W-1:0] in_horizon_line;
  logic                        out_valid;
  logic                        out_ready;
  logic [WIN_W-1:0]            out_window_start;
  logic [WIN_W-1:0]            out_window_end;
  logic                        out_box_empty;
  logic signed [COORD_W-1:0]   out_box_x_min;
  logic signed [COORD_W-1:0]   out_box_y_min;
  logic signed [COORD_W-1:0]   out_box_x_max;
  logic signed [COORD_W-1:0]   out_box_y_max;
  logic                        cfg_wr_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_wdata;

  span_req_t   cur_req;
  span_req_t   pending_requests[$];
  window_rpt_t due_windows[$];
  logic        in_taken;
  int          queued;
  int          fail_count;
  int          quiet_cycles;
  int          in_idle_pct;
  int          out_idle_pct;

  // shadow state of the block
  int span_lo[LINES];
  int span_hi[LINES];
  int box_xl, box_yt, box_xr, box_yb;
  int line_ctr, col_org;

  scanline_span_accumulator_unit u_top (.*);

  // request payload follows the current request
  assign in_operation    = cur_req.op;
  assign in_left_x       = cur_req.lx;
  assign in_top_y        = cur_req.ty;
  assign in_right_x      = cur_req.rx;
  assign in_bottom_y     = cur_req.by;
  assign in_line_index   = cur_req.line;
  assign in_horizon_line = cur_req.hz;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic reset_box();
    box_xl = VIEW / 2;
    box_yt = LINES / 2;
    box_xr = -(VIEW / 2);
    box_yb = -(LINES / 2);
  endtask

  task automatic clear_spans();
    reset_box();
    for (int i = 0; i < LINES; i++) begin
      span_lo[i] = SPAN_NONE;
      span_hi[i] = -1;
    end
  endtask

  // advance the shadow state by one request, queue the window a read returns
  task automatic accumulate_request(input span_req_t r);
    int x0, y0, x1, y1;
    window_rpt_t w;
    case (r.op)
      OP_CLEAR_ALL: clear_spans();
      OP_CLEAR_BOX: reset_box();
      OP_ADD_QUAD: begin
        x0 = r.lx;
        y0 = r.ty;
        x1 = r.rx;
        y1 = r.by;
        // box grows with the raw corners
        if (x0 < box_xl) box_xl = x0;
        if (y0 < box_yt) box_yt = y0;
        if (x1 > box_xr) box_xr = x1;
        if (y1 > box_yb) box_yb = y1;
        // shift to screen lines and columns, then clip
        y0 += line_ctr;
        y1 += line_ctr;
        if (y0 < 0) y0 = 0;
        if (y1 > LINES - 1) y1 = LINES - 1;
        x0 += VIEW / 2 + col_org;
        x1 += VIEW / 2 + col_org;
        if (x0 < col_org) x0 = col_org;
        if (x1 > VIEW - 1 + col_org) x1 = VIEW - 1 + col_org;
        if (x1 >= x0) begin
          for (int y = y0; y <= y1; y++) begin
            if (x0 < span_lo[y]) span_lo[y] = x0;
            if (x1 > span_hi[y]) span_hi[y] = x1;
          end
        end
      end
      default: begin
        w.wstart = SHUT_START;
        w.wend = SHUT_END;
        if (r.line < LINES) begin
          if (span_lo[r.line] <= span_hi[r.line] && int'(r.line) >= int'(r.hz)) begin
            w.wstart = span_lo[r.line][WIN_W-1:0];
            w.wend = span_hi[r.line][WIN_W-1:0];
          end
        end
        w.empty = (box_xl > box_xr) || (box_yt > box_yb);
        w.xmin = box_xl[COORD_W-1:0];
        w.ymin = box_yt[COORD_W-1:0];
        w.xmax = box_xr[COORD_W-1:0];
        w.ymax = box_yb[COORD_W-1:0];
        due_windows.push_back(w);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // request driver and result ready, both change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        cur_req <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // monitor: results are checked before a request taken on the same edge is applied
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (due_windows.size() == 0) begin
          $display("%0t: unexpected result, window %0d..%0d", $time, out_window_start,
                   out_window_end);
          fail_count++;
        end else begin
          check_field("window_start", due_windows[0].wstart, out_window_start);
          check_field("window_end", due_windows[0].wend, out_window_end);
          check_field("box_empty", due_windows[0].empty, out_box_empty);
          check_field("box_x_min", due_windows[0].xmin, out_box_x_min);
          check_field("box_y_min", due_windows[0].ymin, out_box_y_min);
          check_field("box_x_max", due_windows[0].xmax, out_box_x_max);
          check_field("box_y_max", due_windows[0].ymax, out_box_y_max);
          void'(due_windows.pop_front());
        end
      end
      if (in_valid && in_ready) accumulate_request(cur_req);
    end
    // watchdog counter
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_req(input op_t op, input int lx, input int ty, input int rx,
                           input int by, input int line, input int hz);
    span_req_t r;
    r.op = op;
    r.lx = COORD_W'(lx);
    r.ty = COORD_W'(ty);
    r.rx = COORD_W'(rx);
    r.by = COORD_W'(by);
    r.line = LINE_IN_W'(line);
    r.hz = HORIZON_W'(hz);
    pending_requests.push_back(r);
    queued++;
  endtask

  // mostly visible quads, some fully random, some inverted
  task automatic queue_random_quad();
    int pick, lx, ty, w, h;
    pick = $urandom_range(0, 99);
    lx = int'($urandom_range(0, 440)) - 220;
    ty = int'($urandom_range(0, 259)) - line_ctr - 10;
    if (pick < 70) begin
      w = $urandom_range(0, 160);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 260) : $urandom_range(0, 30);
      queue_req(OP_ADD_QUAD, lx, ty, lx + w, ty + h, 0, 0);
    end else if (pick < 85) begin
      queue_req(OP_ADD_QUAD, int'($urandom_range(0, 2047)) - 1024,
                int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                int'($urandom_range(0, 2047)) - 1024, 0, 0);
    end else if (pick < 93) begin
      queue_req(OP_ADD_QUAD, lx, ty, lx - 1 - int'($urandom_range(0, 100)), ty + 5, 0, 0);
    end else begin
      queue_req(OP_ADD_QUAD, lx, ty, lx + 20, ty - 1 - int'($urandom_range(0, 50)), 0, 0);
    end
  endtask

  task automatic queue_random_read();
    int line, hz, pick;
    line = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 239);
    pick = $urandom_range(0, 99);
    if (pick < 50) hz = int'($urandom_range(0, 511)) - 512;
    else if (pick < 80) hz = line + int'($urandom_range(0, 6)) - 3;
    else hz = int'($urandom_range(0, 1023)) - 512;
    queue_req(OP_READ_LINE, 0, 0, 0, 0, line, hz);
  endtask

  // a frame: a clear, then quads and reads, with a little noise
  task automatic queue_frame();
    int n, pick;
    queue_req(($urandom_range(0, 4) == 0) ? OP_CLEAR_BOX : OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0);
    n = $urandom_range(3, 20);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_random_quad();
      else if (pick < 90) queue_random_read();
      else if (pick < 95) queue_req(OP_CLEAR_BOX, 0, 0, 0, 0, 0, 0);
      else queue_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), $urandom_range(0, 255),
                     $urandom_range(0, 1023));
    end
  endtask

  // block drained: every request taken, every window back, last sweep done
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || due_windows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    if (idx == REG_LINE_CENTER) line_ctr = val & 'hff;
    else col_org = val & 'hff;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int center, input int origin, input int idle,
                           input int count);
    int target;
    wait_idle();
    set_register(REG_LINE_CENTER, center);
    set_register(REG_COLUMN_ORIGIN, origin);
    in_idle_pct = idle;
    out_idle_pct = idle;
    target = queued + count;
    while (queued < target) queue_frame();
  endtask

  initial begin
    cur_req = '{OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0};
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_LINE_CENTER;
    cfg_wdata = '0;
    in_idle_pct = 19;
    out_idle_pct = 19;
    queued = 0;
    fail_count = 0;
    quiet_cycles = 0;
    line_ctr = LINE_CENTER_RESET;
    col_org = COLUMN_ORIGIN_RESET;
    clear_spans();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_phase(LINE_CENTER_RESET, COLUMN_ORIGIN_RESET, 19, 0);
    // directed: state after reset, then the widest quad
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 0, -512);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 255, -512);
    queue_req(OP_ADD_QUAD, -1024, -1024, 1023, 1023, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 0, -512);
    // horizon equal to the line keeps it open, one above shuts it
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 239, 239);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 100, 101);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 240, -1);
    // box-only clear keeps spans, full clear empties them
    queue_req(OP_CLEAR_BOX, 0, 0, 0, 0, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 5, 0);
    queue_req(OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 5, 0);
    // rows past the bottom: box only
    queue_req(OP_ADD_QUAD, -5, 200, 5, 900, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 239, -512);
    // inverted columns, columns off right, columns off left with rows off top
    queue_req(OP_ADD_QUAD, 50, 0, -50, 0, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 120, 0);
    queue_req(OP_ADD_QUAD, 500, -10, 700, 10, 0, 0);
    queue_req(OP_ADD_QUAD, -700, -1024, -400, -121, 0, 0);
    // overlapping quads widen a span on the right
    queue_req(OP_ADD_QUAD, -10, 0, 10, 0, 0, 0);
    queue_req(OP_ADD_QUAD, -3, 0, 40, 2, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 120, -512);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 122, 0);
    // exactly the screen, then the top horizon
    queue_req(OP_ADD_QUAD, -160, -120, 159, 119, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 0, 0);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 239, -1);
    queue_req(OP_READ_LINE, 0, 0, 0, 0, 60, 511);

    // random frames under several settings, one phase with no idling
    run_phase(LINE_CENTER_RESET, COLUMN_ORIGIN_RESET, 19, 250);
    run_phase(0, 0, 0, 250);
    run_phase(255, 255, 19, 300);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), 19, 300);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), 19, 350);
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/ssa_ctrl.sv
sv/ssa_dp.sv
sv/scanline_span_accumulator_unit.sv
tb/tb_top.sv
